[rtl/bam_pkg.sv]
// shared types, constants and register codes for the battery adc monitor
// depends on nothing; imported by bam_addsub and battery_adc_monitor
package bam_pkg;

  // field widths
  localparam int ADC_W   = 12;
  localparam int V_W     = 23;
  localparam int PCT_W   = 7;
  localparam int ST_W    = 2;
  localparam int CFG_IW  = 3;

  // default for the adc resolution parameter
  localparam int ADC_BITS_DEF = 12;

  // shared subtractor width: one bit above the voltage width
  localparam int AW = V_W + 1;

  // width of |voltage - min| * 100, and the number of divide steps
  localparam int NUM_W     = 30;
  localparam int DIV_STEPS = NUM_W;

  // scaling constants
  localparam logic [19:0] LO_COEF    = 20'd78125;
  localparam logic [19:0] HI_COEF    = 20'd924375;
  localparam int          LO_SHIFT   = 7;
  localparam int          HI_SHIFT   = 9;
  localparam logic [V_W-1:0] HI_OFFSET  = 23'd33000;
  localparam logic [V_W-1:0] LO_LIMIT   = 23'd2500000;
  localparam logic [V_W-1:0] MOVE_LIMIT = 23'd50000;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // register reset values
  localparam logic [V_W-1:0] MAX_V_RST = 23'd4200000;
  localparam logic [V_W-1:0] MIN_V_RST = 23'd3600000;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_MAX_V      = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_MIN_V      = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_DET_PRES   = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_ACTIVE_LOW = 3'd3;

  // charge status codes
  localparam logic [ST_W-1:0] ST_UNKNOWN      = 2'd0;
  localparam logic [ST_W-1:0] ST_CHARGING     = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_CHARGING = 2'd2;

  typedef struct packed {
    logic [ADC_W-1:0] adc_sample;
    logic             sample_ok;
    logic             charger_level;
  } in_beat_t;

  typedef struct packed {
    logic [V_W-1:0]   voltage_uv;
    logic [PCT_W-1:0] capacity_pct;
    logic             health_low;
    logic [ST_W-1:0]  charge_status;
    logic             changed;
    logic             sample_error;
  } out_beat_t;

  // request to and response from the shared subtractor
  typedef struct packed {
    logic [AW-1:0] a;
    logic [AW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [AW-1:0] res;
    logic          borrow;
  } alu_rsp_t;

endpackage

[rtl/bam_addsub.sv]
// shared subtractor with borrow out, used for every difference and divide step
// depends on bam_pkg
module bam_addsub (
  input  bam_pkg::alu_req_t req,
  output bam_pkg::alu_rsp_t rsp
);
  import bam_pkg::*;

  logic [AW:0] diff;

  // a - b with one guard bit for the borrow
  assign diff       = {1'b0, req.a} - {1'b0, req.b};
  assign rsp.res    = diff[AW-1:0];
  assign rsp.borrow = diff[AW];

endmodule

[rtl/battery_adc_monitor.sv]
// battery adc monitor: scales a sample to microvolts and derives capacity,
// health, charge status and a change flag; depends on bam_pkg and bam_addsub
// sequence: a failed sample goes straight to the result register; otherwise scaling
// (multiply, then shift and offset), three differences on the shared subtractor, the
// times-100 step, 30 divide steps unless the capacity is forced to zero, then commit
// throughput: one beat at a time; a new beat is taken the cycle after the previous
// one is committed, and commit waits while the result register is still held
// synchronous active-low reset
module battery_adc_monitor #(
  parameter int ADC_BITS = bam_pkg::ADC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bam_pkg::in_beat_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bam_pkg::out_beat_t         out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bam_pkg::CFG_IW-1:0] cfg_index,
  input  logic [bam_pkg::V_W-1:0]    cfg_data
);
  import bam_pkg::*;

  localparam int SW  = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
  localparam int CW  = $clog2(DIV_STEPS);
  localparam logic [CW-1:0] DIV_LAST = CW'(DIV_STEPS - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_SCALE = 3'd2;
  localparam logic [2:0] S_ABS   = 3'd3;
  localparam logic [2:0] S_PCT   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  // difference being taken on the shared subtractor
  localparam logic [1:0] OP_SPAN = 2'd0;
  localparam logic [1:0] OP_NUM  = 2'd1;
  localparam logic [1:0] OP_MOVE = 2'd2;

  logic [2:0]       state_r, state_nxt;
  logic [1:0]       op_r, op_nxt;
  logic             swap_r, swap_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  logic [V_W-1:0]   max_v_r, min_v_r;
  logic             det_pres_r, active_low_r;
  logic [V_W-1:0]   last_v_r, last_v_nxt;
  logic [ST_W-1:0]  last_st_r, last_st_nxt;

  logic [SW-1:0]    sample_r;
  logic             ok_r, level_r;
  logic [31:0]      prod_r;
  logic [V_W-1:0]   v_r;
  logic [V_W-1:0]   span_r, num_r, move_r;
  logic             span_neg_r, num_neg_r;
  logic [V_W-1:0]   rem_r, rem_nxt;
  logic [NUM_W-1:0] dvd_r, dvd_nxt;

  logic             out_valid_r;
  out_beat_t        out_data_r;

  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;
  logic [AW-1:0]    op_a, op_b;
  logic [AW-1:0]    trial;
  logic             low_range;
  logic [19:0]      coef;
  logic             slot_free;
  logic             pct_zero;
  logic [PCT_W-1:0] pct;
  logic [ST_W-1:0]  st_new;
  logic             st_chg, v_chg;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign slot_free = !out_valid_r || out_ready;

  // configuration registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_v_r      <= MAX_V_RST;
      min_v_r      <= MIN_V_RST;
      det_pres_r   <= 1'b0;
      active_low_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAX_V:      max_v_r      <= cfg_data;
        CFG_MIN_V:      min_v_r      <= cfg_data;
        CFG_DET_PRES:   det_pres_r   <= cfg_data[0];
        CFG_ACTIVE_LOW: active_low_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // range select and scaling coefficient
  assign low_range = (max_v_r <= LO_LIMIT);
  assign coef      = low_range ? LO_COEF : HI_COEF;

  // operand selection for the shared subtractor
  assign trial = {rem_r, dvd_r[NUM_W-1]};
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state_r == S_DIV) begin
      op_a = trial;
      op_b = {1'b0, span_r};
    end else begin
      case (op_r)
        OP_SPAN: begin
          op_a = {1'b0, max_v_r};
          op_b = {1'b0, min_v_r};
        end
        OP_NUM: begin
          op_a = {1'b0, v_r};
          op_b = {1'b0, min_v_r};
        end
        OP_MOVE: begin
          op_a = {1'b0, v_r};
          op_b = {1'b0, last_v_r};
        end
        default: ;
      endcase
    end
    alu_req.a = swap_r ? op_b : op_a;
    alu_req.b = swap_r ? op_a : op_b;
  end

  bam_addsub u_addsub (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // result fields and state updates at commit
  assign pct_zero = !ok_r || (span_r == '0) || (num_neg_r != span_neg_r);
  assign pct      = pct_zero ? '0
                  : ((dvd_r > NUM_W'(PCT_FULL)) ? PCT_FULL : dvd_r[PCT_W-1:0]);
  assign st_new   = (level_r ^ active_low_r) ? ST_CHARGING : ST_NOT_CHARGING;
  assign st_chg   = det_pres_r && (st_new != last_st_r);
  assign v_chg    = ok_r && (move_r > MOVE_LIMIT);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    swap_nxt    = swap_r;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    dvd_nxt     = dvd_r;
    last_v_nxt  = last_v_r;
    last_st_nxt = last_st_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = in_data.sample_ok ? S_MUL : S_DONE;
          op_nxt    = OP_SPAN;
          swap_nxt  = 1'b0;
        end
      end
      S_MUL:   state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_ABS;
      S_ABS: begin
        if (!swap_r && alu_rsp.borrow) begin
          swap_nxt = 1'b1;
        end else begin
          swap_nxt = 1'b0;
          if (op_r == OP_MOVE) begin
            state_nxt = S_PCT;
          end else begin
            op_nxt = op_r + 2'd1;
          end
        end
      end
      S_PCT: begin
        dvd_nxt   = NUM_W'(num_r) * NUM_W'(PCT_FULL);
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = pct_zero ? S_DONE : S_DIV;
      end
      S_DIV: begin
        // one restoring step: keep the difference when it does not borrow
        rem_nxt = alu_rsp.borrow ? trial[V_W-1:0] : alu_rsp.res[V_W-1:0];
        dvd_nxt = {dvd_r[NUM_W-2:0], !alu_rsp.borrow};
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
          if (st_chg) last_st_nxt = st_new;
          if (v_chg)  last_v_nxt  = v_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_SPAN;
      swap_r      <= 1'b0;
      cnt_r       <= '0;
      last_v_r    <= '0;
      last_st_r   <= ST_UNKNOWN;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      op_r      <= op_nxt;
      swap_r    <= swap_nxt;
      cnt_r     <= cnt_nxt;
      last_v_r  <= last_v_nxt;
      last_st_r <= last_st_nxt;
      if (state_r == S_DONE && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    // capture the input beat, masked to the adc resolution
    if (in_valid && in_ready) begin
      sample_r <= in_data.adc_sample[SW-1:0];
      ok_r     <= in_data.sample_ok;
      level_r  <= in_data.charger_level;
    end
    // product of sample and range coefficient
    if (state_r == S_MUL) begin
      prod_r <= 32'(sample_r) * {12'd0, coef};
    end
    // shift and offset to microvolts
    if (state_r == S_SCALE) begin
      v_r <= low_range ? V_W'(prod_r >> LO_SHIFT)
                       : V_W'(prod_r >> HI_SHIFT) + HI_OFFSET;
    end
    // magnitudes and signs of the three differences
    if (state_r == S_ABS && (swap_r || !alu_rsp.borrow)) begin
      case (op_r)
        OP_SPAN: begin
          span_r     <= alu_rsp.res[V_W-1:0];
          span_neg_r <= swap_r;
        end
        OP_NUM: begin
          num_r     <= alu_rsp.res[V_W-1:0];
          num_neg_r <= swap_r;
        end
        OP_MOVE: move_r <= alu_rsp.res[V_W-1:0];
        default: ;
      endcase
    end
    // result register
    if (state_r == S_DONE && slot_free) begin
      out_data_r.voltage_uv    <= ok_r ? v_r : '0;
      out_data_r.capacity_pct  <= pct;
      out_data_r.health_low    <= !ok_r || num_neg_r;
      out_data_r.charge_status <= st_chg ? st_new : last_st_r;
      out_data_r.changed       <= st_chg || v_chg;
      out_data_r.sample_error  <= !ok_r;
    end
  end

  // a failed conversion goes straight to commit
  a_fail_skips: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_data.sample_ok) |=> (state_r == S_DONE))
    else $error("failed sample did not skip the arithmetic");

  // a failed conversion reports zero voltage and capacity with low health
  a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.sample_error) |->
      (out_data.voltage_uv == '0 && out_data.capacity_pct == '0 && out_data.health_low))
    else $error("failed sample reported non-zero fields");

  // capacity never exceeds full scale
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.capacity_pct <= PCT_FULL))
    else $error("capacity above full scale");

  // the divide ends after its last step
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == DIV_LAST) |=> (state_r == S_DONE))
    else $error("divide overran its step count");

endmodule
